FILE: hw/rtl/chb_pkg.sv
`timescale 1ns / 1ps

package chb_pkg;

  // Field widths of the item payloads.
  localparam int POS_W   = 32;
  localparam int DIR_W   = 16;
  localparam int DIST_W  = 31;
  localparam int RND_W   = 16;
  localparam int FRAC_SH = 14;
  localparam int ONE_Q14 = 1 << FRAC_SH;

  // Normalizer: component width, radicand width, root and divider depths, and total depth.
  localparam int SUM_W      = 28;
  localparam int SQRT_W     = 2 * SUM_W;
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int DIV_STEPS  = DIR_W;
  localparam int NORM_LAT   = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // Rotation unit for cosine and sine, angles in 2^32 per turn.
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_W     = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F
  };

  typedef logic signed [SUM_W-1:0] nvec_t;

  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic signed [POS_W-1:0] origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [DIST_W-1:0]       distance;
    logic signed [DIR_W-1:0] normal_x;
    logic signed [DIR_W-1:0] normal_y;
    logic signed [DIR_W-1:0] normal_z;
    logic [RND_W-1:0]        rand_angle;
    logic [RND_W-1:0]        rand_radius;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] hit_x;
    logic signed [POS_W-1:0] hit_y;
    logic signed [POS_W-1:0] hit_z;
    logic signed [DIR_W-1:0] bounce_x;
    logic signed [DIR_W-1:0] bounce_y;
    logic signed [DIR_W-1:0] bounce_z;
  } out_t;

endpackage

FILE: hw/rtl/chb_isqrt.sv
`timescale 1ns / 1ps

module chb_isqrt import chb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [SQRT_W-1:0]     rad_i,
  output logic [SQRT_STEPS-1:0] root_o
);

  localparam int AW = SQRT_W + 1;

  logic [AW-1:0] rem_q [SQRT_STEPS];
  logic [AW-1:0] res_q [SQRT_STEPS];
  logic [AW-1:0] rem_d [SQRT_STEPS];
  logic [AW-1:0] res_d [SQRT_STEPS];
  logic [AW-1:0] prv_rem [SQRT_STEPS];
  logic [AW-1:0] prv_res [SQRT_STEPS];
  logic [AW-1:0] trial [SQRT_STEPS];

  // One result bit per stage, highest first.
  always_comb begin
    prv_rem[0] = AW'(rad_i);
    prv_res[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      prv_rem[k] = rem_q[k-1];
      prv_res[k] = res_q[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      trial[k] = prv_res[k] + (AW'(1) << (SQRT_W - 2 - 2 * k));
      if (prv_rem[k] >= trial[k]) begin
        rem_d[k] = prv_rem[k] - trial[k];
        res_d[k] = (prv_res[k] >> 1) + (AW'(1) << (SQRT_W - 2 - 2 * k));
      end else begin
        rem_d[k] = prv_rem[k];
        res_d[k] = prv_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign root_o = res_q[SQRT_STEPS-1][SQRT_STEPS-1:0];

endmodule

FILE: hw/rtl/chb_norm.sv
`timescale 1ns / 1ps

module chb_norm import chb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  nvec_t                   vec_i [3],
  output logic signed [DIR_W-1:0] unit_o [3]
);

  localparam int C_DLY = 2 + SQRT_STEPS;
  localparam int NUM_W = SUM_W + FRAC_SH;
  localparam int CMP_W = SQRT_STEPS + DIV_STEPS;

  // Squares and their sum.
  logic [SQRT_W-1:0] sq_q [3];
  logic [SQRT_W-1:0] sq_d [3];
  logic signed [SQRT_W-1:0] sqp [3];
  logic [SQRT_W-1:0] ssum_q;
  logic [SQRT_STEPS-1:0] root;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp[i]  = vec_i[i] * vec_i[i];
      sq_d[i] = sqp[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      ssum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  chb_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (ssum_q),
    .root_o (root)
  );

  // Components wait for the length.
  nvec_t cdl_q [C_DLY][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cdl_q[0] <= vec_i;
      for (int k = 1; k < C_DLY; k++) begin
        cdl_q[k] <= cdl_q[k-1];
      end
    end
  end

  // Restoring division of |c|*2^14 by the length, one quotient bit per stage.
  logic [NUM_W-1:0]      drem_q [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0]  dquo_q [DIV_STEPS+1][3];
  logic                  dneg_q [DIV_STEPS+1][3];
  logic                  dzero_q [DIV_STEPS+1][3];
  logic                  dsat_q [DIV_STEPS+1][3];
  logic [SQRT_STEPS-1:0] dlen_q [DIV_STEPS+1];

  logic [NUM_W-1:0]      drem_d [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0]  dquo_d [DIV_STEPS+1][3];
  logic [SUM_W-1:0]      mag [3];
  logic [CMP_W-1:0]      dvs [DIV_STEPS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]          = cdl_q[C_DLY-1][i][SUM_W-1] ? SUM_W'(-cdl_q[C_DLY-1][i])
                                                   : SUM_W'(cdl_q[C_DLY-1][i]);
      drem_d[0][i]    = {mag[i], {FRAC_SH{1'b0}}};
      dquo_d[0][i]    = '0;
    end
    dvs[0] = {root, {DIV_STEPS{1'b0}}};
    for (int j = 1; j <= DIV_STEPS; j++) begin
      dvs[j] = CMP_W'(dlen_q[j-1]) << (DIV_STEPS - j);
      for (int i = 0; i < 3; i++) begin
        if (CMP_W'(drem_q[j-1][i]) >= dvs[j]) begin
          drem_d[j][i] = drem_q[j-1][i] - NUM_W'(dvs[j]);
          dquo_d[j][i] = dquo_q[j-1][i] | (DIV_STEPS'(1) << (DIV_STEPS - j));
        end else begin
          drem_d[j][i] = drem_q[j-1][i];
          dquo_d[j][i] = dquo_q[j-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dlen_q[0] <= root;
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i]  <= drem_d[0][i];
        dquo_q[0][i]  <= dquo_d[0][i];
        dneg_q[0][i]  <= cdl_q[C_DLY-1][i][SUM_W-1];
        dzero_q[0][i] <= (mag[i] == '0);
        dsat_q[0][i]  <= (CMP_W'(drem_d[0][i]) >= dvs[0]);
      end
      for (int j = 1; j <= DIV_STEPS; j++) begin
        dlen_q[j] <= dlen_q[j-1];
        for (int i = 0; i < 3; i++) begin
          drem_q[j][i]  <= drem_d[j][i];
          dquo_q[j][i]  <= dquo_d[j][i];
          dneg_q[j][i]  <= dneg_q[j-1][i];
          dzero_q[j][i] <= dzero_q[j-1][i];
          dsat_q[j][i]  <= dsat_q[j-1][i];
        end
      end
    end
  end

  // Sign, clamp and zero handling.
  logic [DIV_STEPS-1:0]    qm [3];
  logic signed [DIR_W-1:0] unit_d [3];
  logic signed [DIR_W-1:0] unit_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i] = dsat_q[DIV_STEPS][i] ? '1 : dquo_q[DIV_STEPS][i];
      if (dzero_q[DIV_STEPS][i]) begin
        unit_d[i] = '0;
      end else if (dneg_q[DIV_STEPS][i]) begin
        unit_d[i] = qm[i][DIV_STEPS-1] ? {1'b1, {(DIR_W-1){1'b0}}}
                                       : -$signed({1'b0, qm[i][DIV_STEPS-2:0]});
      end else begin
        unit_d[i] = qm[i][DIV_STEPS-1] ? {1'b0, {(DIR_W-1){1'b1}}}
                                       : $signed({1'b0, qm[i][DIV_STEPS-2:0]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
    end
  end

  assign unit_o = unit_q;

endmodule

FILE: hw/rtl/cosine_hemisphere_bounce.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; the depth is set
// by the two normalizers (sum of squares, 28-stage square root, 16-stage divider).
// Reset clears only the valid bits of the pipeline; there is no memory to clear.
// An output stall freezes every stage at once.

module cosine_hemisphere_bounce import chb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // Stage positions, counted in registers after the input register.
  localparam int ST_A   = 3;
  localparam int ST_U   = ST_A + NORM_LAT;
  localparam int ST_V   = ST_U + 2;
  localparam int ST_M1  = ST_V + 1;
  localparam int ST_SUM = ST_V + 3;
  localparam int ST_OUT = ST_SUM + NORM_LAT;
  localparam int ST_CS  = 1 + CORDIC_STEPS;
  localparam int ST_RS  = SQRT_STEPS;

  localparam int HIT_DLY = ST_OUT - 1;
  localparam int W_DLY   = ST_V - 1;
  localparam int CS_DLY  = ST_V - ST_CS + 1;
  localparam int RS_DLY  = ST_M1 - ST_RS;
  localparam int RS_TAP1 = ST_V - ST_RS - 1;

  localparam int HP_W  = POS_W + DIR_W;
  localparam int HS_W  = POS_W + 3;
  localparam int NP_W  = 2 * DIR_W;
  localparam int DOT_W = NP_W + 2;
  localparam int W_W   = DIR_W + 1;
  localparam int CP_W  = W_W + DIR_W;
  localparam int V_W   = DIR_W + 3;
  localparam int CS_W  = CORDIC_W - DIR_W + 1;
  localparam int RS_W  = FRAC_SH + 1;
  localparam int RR_SH = 12;
  localparam int UC_W  = DIR_W + CS_W;
  localparam int VS_W  = V_W + CS_W;
  localparam int WR_W  = W_W + RS_W + 1;
  localparam int T_W   = VS_W + RS_W + 2;
  localparam int SUM_SH = 20;
  localparam int AXIS_GAIN = 10;

  localparam logic signed [HS_W-1:0] POS_MAX = {{(HS_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [HS_W-1:0] POS_MIN = ~POS_MAX;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Pipeline control: all stages move together unless the output item is held.
  logic            en;
  logic [ST_OUT:0] vld_q;

  assign en         = !(vld_q[ST_OUT] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ST_OUT-1:0], in_valid_i};
    end
  end

  // Input register.
  in_t in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  // Stage 1: hit-point and facing products.
  logic signed [DIR_W-1:0] dir_s [3];
  logic signed [DIR_W-1:0] nrm_s [3];
  logic signed [POS_W-1:0] org_s [3];
  logic signed [HP_W-1:0]  hp_d [3];
  logic signed [HP_W-1:0]  hp_q [3];
  logic signed [NP_W-1:0]  np_d [3];
  logic signed [NP_W-1:0]  np_q [3];
  logic signed [POS_W-1:0] org1_q [3];
  logic signed [DIR_W-1:0] nrm1_q [3];

  always_comb begin
    dir_s[0] = in_q.dir_x;
    dir_s[1] = in_q.dir_y;
    dir_s[2] = in_q.dir_z;
    nrm_s[0] = in_q.normal_x;
    nrm_s[1] = in_q.normal_y;
    nrm_s[2] = in_q.normal_z;
    org_s[0] = in_q.origin_x;
    org_s[1] = in_q.origin_y;
    org_s[2] = in_q.origin_z;
    for (int i = 0; i < 3; i++) begin
      hp_d[i] = $signed({1'b0, in_q.distance}) * dir_s[i];
      np_d[i] = nrm_s[i] * dir_s[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hp_q   <= hp_d;
      np_q   <= np_d;
      org1_q <= org_s;
      nrm1_q <= nrm_s;
    end
  end

  // Stage 2: saturated hit point and the normal turned against the ray.
  logic signed [HS_W-1:0]  hs [3];
  logic signed [POS_W-1:0] hit_d [3];
  logic signed [DOT_W-1:0] dot;
  logic signed [W_W-1:0]   w_d [3];
  logic signed [POS_W-1:0] hit_dl_q [HIT_DLY][3];
  logic signed [W_W-1:0]   w_dl_q [W_DLY][3];

  always_comb begin
    dot = DOT_W'(np_q[0]) + DOT_W'(np_q[1]) + DOT_W'(np_q[2]);
    for (int i = 0; i < 3; i++) begin
      hs[i] = HS_W'(org1_q[i]) + HS_W'(hp_q[i] >>> FRAC_SH);
      if (hs[i] > POS_MAX) begin
        hit_d[i] = POS_MAX[POS_W-1:0];
      end else if (hs[i] < POS_MIN) begin
        hit_d[i] = POS_MIN[POS_W-1:0];
      end else begin
        hit_d[i] = hs[i][POS_W-1:0];
      end
      w_d[i] = dot[DOT_W-1] ? W_W'(nrm1_q[i]) : -W_W'(nrm1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_dl_q[0] <= hit_d;
      for (int k = 1; k < HIT_DLY; k++) begin
        hit_dl_q[k] <= hit_dl_q[k-1];
      end
      w_dl_q[0] <= w_d;
      for (int k = 1; k < W_DLY; k++) begin
        w_dl_q[k] <= w_dl_q[k-1];
      end
    end
  end

  // Stage 3: helper axis for the tangent, crossed with w.
  logic [W_W-1:0]          absw;
  logic                    big_x;
  logic signed [W_W-1:0]   a_d [3];
  logic signed [W_W-1:0]   a_q [3];
  nvec_t                   a_vec [3];
  logic signed [DIR_W-1:0] u_s [3];

  always_comb begin
    absw  = w_dl_q[0][0][W_W-1] ? W_W'(-w_dl_q[0][0]) : W_W'(w_dl_q[0][0]);
    big_x = ((W_W + 4)'(absw) * (W_W + 4)'(AXIS_GAIN)) > (W_W + 4)'(ONE_Q14);
    if (big_x) begin
      a_d[0] = w_dl_q[0][2];
      a_d[1] = '0;
      a_d[2] = -w_dl_q[0][0];
    end else begin
      a_d[0] = '0;
      a_d[1] = -w_dl_q[0][2];
      a_d[2] = w_dl_q[0][1];
    end
    for (int i = 0; i < 3; i++) begin
      a_vec[i] = SUM_W'(a_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  chb_norm u_norm_tangent (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (a_vec),
    .unit_o (u_s)
  );

  // Cosine and sine of the azimuth: quadrant fold, then one rotation per stage.
  logic [RND_W-1:0]           ang_sh;
  logic [1:0]                 quad0;
  logic [RND_W-1:0]           ang_rem;
  logic signed [CORDIC_W-1:0] px [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] py [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] pz [CORDIC_STEPS];
  logic [1:0]                 pq [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cx_d [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy_d [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cz_d [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cx_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cz_q [CORDIC_STEPS];
  logic [1:0]                 cq_q [CORDIC_STEPS];

  always_comb begin
    ang_sh  = in_q.rand_angle + RND_W'(1 << (RND_W - 3));
    quad0   = ang_sh[RND_W-1:RND_W-2];
    ang_rem = in_q.rand_angle - {quad0, {(RND_W-2){1'b0}}};
    px[0] = CORDIC_GAIN;
    py[0] = '0;
    pz[0] = CORDIC_W'($signed(ang_rem)) <<< RND_W;
    pq[0] = quad0;
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      px[k] = cx_q[k-1];
      py[k] = cy_q[k-1];
      pz[k] = cz_q[k-1];
      pq[k] = cq_q[k-1];
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (!pz[k][CORDIC_W-1]) begin
        cx_d[k] = px[k] - (py[k] >>> k);
        cy_d[k] = py[k] + (px[k] >>> k);
        cz_d[k] = pz[k] - $signed(CORDIC_W'(ATAN_TURN[k]));
      end else begin
        cx_d[k] = px[k] + (py[k] >>> k);
        cy_d[k] = py[k] - (px[k] >>> k);
        cz_d[k] = pz[k] + $signed(CORDIC_W'(ATAN_TURN[k]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
      cq_q <= pq;
    end
  end

  logic signed [CORDIC_W-1:0] cfin;
  logic signed [CORDIC_W-1:0] sfin;
  logic signed [CS_W-1:0]     cs_dl_q [CS_DLY];
  logic signed [CS_W-1:0]     sn_dl_q [CS_DLY];

  always_comb begin
    unique case (cq_q[CORDIC_STEPS-1])
      QUAD_0: begin
        cfin = cx_q[CORDIC_STEPS-1];
        sfin = cy_q[CORDIC_STEPS-1];
      end
      QUAD_1: begin
        cfin = -cy_q[CORDIC_STEPS-1];
        sfin = cx_q[CORDIC_STEPS-1];
      end
      QUAD_2: begin
        cfin = -cx_q[CORDIC_STEPS-1];
        sfin = -cy_q[CORDIC_STEPS-1];
      end
      QUAD_3: begin
        cfin = cy_q[CORDIC_STEPS-1];
        sfin = -cx_q[CORDIC_STEPS-1];
      end
      default: begin
        cfin = '0;
        sfin = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_dl_q[0] <= CS_W'(cfin >>> RND_W);
      sn_dl_q[0] <= CS_W'(sfin >>> RND_W);
      for (int k = 1; k < CS_DLY; k++) begin
        cs_dl_q[k] <= cs_dl_q[k-1];
        sn_dl_q[k] <= sn_dl_q[k-1];
      end
    end
  end

  // Radial weights sqrt(r) and sqrt(1-r).
  logic [SQRT_W-1:0]     r2_rad;
  logic [SQRT_W-1:0]     r1_rad;
  logic [SQRT_STEPS-1:0] r2_root;
  logic [SQRT_STEPS-1:0] r1_root;
  logic [RND_W:0]        rr_inv;
  logic [RS_W-1:0]       r2_dl_q [RS_DLY];
  logic [RS_W-1:0]       r1_dl_q [RS_DLY];

  always_comb begin
    rr_inv = (RND_W + 1)'(1 << RND_W) - (RND_W + 1)'(in_q.rand_radius);
    r2_rad = SQRT_W'({in_q.rand_radius, {RR_SH{1'b0}}});
    r1_rad = SQRT_W'({rr_inv, {RR_SH{1'b0}}});
  end

  chb_isqrt u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (r2_rad),
    .root_o (r2_root)
  );

  chb_isqrt u_sqrt_rinv (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (r1_rad),
    .root_o (r1_root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_dl_q[0] <= r2_root[RS_W-1:0];
      r1_dl_q[0] <= r1_root[RS_W-1:0];
      for (int k = 1; k < RS_DLY; k++) begin
        r2_dl_q[k] <= r2_dl_q[k-1];
        r1_dl_q[k] <= r1_dl_q[k-1];
      end
    end
  end

  // Binormal v = w x u, products then difference.
  logic signed [CP_W-1:0]  cp_d [6];
  logic signed [CP_W-1:0]  cp_q [6];
  logic signed [DIR_W-1:0] u1_q [3];
  logic signed [DIR_W-1:0] u2_q [3];
  logic signed [V_W-1:0]   v_d [3];
  logic signed [V_W-1:0]   v_q [3];

  always_comb begin
    cp_d[0] = w_dl_q[ST_U-2][1] * u_s[2];
    cp_d[1] = w_dl_q[ST_U-2][2] * u_s[1];
    cp_d[2] = w_dl_q[ST_U-2][2] * u_s[0];
    cp_d[3] = w_dl_q[ST_U-2][0] * u_s[2];
    cp_d[4] = w_dl_q[ST_U-2][0] * u_s[1];
    cp_d[5] = w_dl_q[ST_U-2][1] * u_s[0];
    for (int i = 0; i < 3; i++) begin
      v_d[i] = V_W'(((CP_W + 1)'(cp_q[2*i]) - (CP_W + 1)'(cp_q[2*i+1])) >>> FRAC_SH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q <= cp_d;
      u1_q <= u_s;
      v_q  <= v_d;
      u2_q <= u1_q;
    end
  end

  // Weighted sum of the frame axes, two multiply stages and an add.
  logic signed [UC_W-1:0] uc_d [3];
  logic signed [UC_W-1:0] uc_q [3];
  logic signed [VS_W-1:0] vs_d [3];
  logic signed [VS_W-1:0] vs_q [3];
  logic signed [WR_W-1:0] wr_d [3];
  logic signed [WR_W-1:0] wr_q [3];
  logic signed [T_W-1:0]  t1_d [3];
  logic signed [T_W-1:0]  t2_d [3];
  logic signed [T_W-1:0]  t3_d [3];
  logic signed [T_W-1:0]  t1_q [3];
  logic signed [T_W-1:0]  t2_q [3];
  logic signed [T_W-1:0]  t3_q [3];
  logic signed [T_W-1:0]  tsum [3];
  nvec_t                  sum_d [3];
  nvec_t                  sum_q [3];
  logic signed [DIR_W-1:0] d_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uc_d[i] = u2_q[i] * cs_dl_q[CS_DLY-1];
      vs_d[i] = v_q[i] * sn_dl_q[CS_DLY-1];
      wr_d[i] = w_dl_q[ST_V-2][i] * $signed({1'b0, r1_dl_q[RS_TAP1]});
      t1_d[i] = uc_q[i] * $signed({1'b0, r2_dl_q[RS_DLY-1]});
      t2_d[i] = vs_q[i] * $signed({1'b0, r2_dl_q[RS_DLY-1]});
      t3_d[i] = T_W'(wr_q[i]) <<< FRAC_SH;
      tsum[i] = t1_q[i] + t2_q[i] + t3_q[i];
      sum_d[i] = SUM_W'(tsum[i] >>> SUM_SH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      uc_q  <= uc_d;
      vs_q  <= vs_d;
      wr_q  <= wr_d;
      t1_q  <= t1_d;
      t2_q  <= t2_d;
      t3_q  <= t3_d;
      sum_q <= sum_d;
    end
  end

  chb_norm u_norm_bounce (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (sum_q),
    .unit_o (d_s)
  );

  // Output item.
  assign out_valid_o         = vld_q[ST_OUT];
  assign out_data_o.hit_x    = hit_dl_q[HIT_DLY-1][0];
  assign out_data_o.hit_y    = hit_dl_q[HIT_DLY-1][1];
  assign out_data_o.hit_z    = hit_dl_q[HIT_DLY-1][2];
  assign out_data_o.bounce_x = d_s[0];
  assign out_data_o.bounce_y = d_s[1];
  assign out_data_o.bounce_z = d_s[2];

  // A held output item freezes every stage.
  a_hold_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while the output item was held");

  // With no stall, every valid bit moves exactly one stage.
  a_shift_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (vld_q[ST_OUT:1] == $past(vld_q[ST_OUT-1:0])))
    else $error("valid bits did not advance by one stage");

  // The rotation unit yields cosine and sine near unit scale.
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_CS] |-> (cs_dl_q[0] <= 18'sd16400 && cs_dl_q[0] >= -18'sd16400 &&
                      sn_dl_q[0] <= 18'sd16400 && sn_dl_q[0] >= -18'sd16400))
    else $error("cosine or sine out of range");

endmodule

FILE: tb/cosine_hemisphere_bounce_tb.sv
`timescale 1ns / 1ps

module cosine_hemisphere_bounce_tb;
  import chb_pkg::*;

  localparam int LATENCY   = 104;
  localparam int STALL_CAP = 3000;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  out_t bounce_q[$];
  int   n_errors   = 0;
  bit   quiet      = 1'b0;
  int   idle_cnt   = 0;
  int   stall_left = 0;

  cosine_hemisphere_bounce dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Integer square root, floor.
  function automatic longint unsigned isqrt_u(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length in Q2.14; a zero vector stays zero.
  task automatic unit_vec(input longint c[3], output longint o[3]);
    longint unsigned s, len;
    longint q;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(c[i] * c[i]);
    len = isqrt_u(s);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = (c[i] * ONE_Q14) / longint'(len);
        o[i] = q < -32768 ? -32768 : (q > 32767 ? 32767 : q);
      end
    end
  endtask

  // Cosine and sine of a turn fraction, Q2.14, via quadrant fold and rotations.
  task automatic sincos_q14(input logic [15:0] frac, output longint cs, output longint sn);
    logic [31:0] ph, t, d;
    logic [1:0]  q;
    longint z, x, y, nx, ny;
    ph = {frac, 16'h0000};
    t  = ph + 32'h2000_0000;
    q  = t[31:30];
    d  = ph - {q, 30'd0};
    z  = longint'($signed(d));
    x  = 652032874;
    y  = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ATAN_TURN[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ATAN_TURN[i]);
      end
      x = nx;
      y = ny;
    end
    case (q)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    cs = cs >>> 16;
    sn = sn >>> 16;
  endtask

  // Full prediction of one bounce.
  task automatic predict_bounce(input in_t it, output out_t res);
    longint org[3], dr[3], nrm[3], w[3], ax[3], u[3], v[3], sm[3], bd[3];
    longint ray_len, dot, h, cs, sn, r2s, r1s, t, wx;
    longint unsigned rr;
    org  = '{longint'(it.origin_x), longint'(it.origin_y), longint'(it.origin_z)};
    dr   = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
    nrm  = '{longint'(it.normal_x), longint'(it.normal_y), longint'(it.normal_z)};
    ray_len = longint'({1'b0, it.distance});
    rr   = longint'({1'b0, it.rand_radius});
    dot  = 0;
    for (int i = 0; i < 3; i++) dot += nrm[i] * dr[i];
    for (int i = 0; i < 3; i++) begin
      h = org[i] + ((ray_len * dr[i]) >>> 14);
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      sm[i] = h;
      w[i]  = dot < 0 ? nrm[i] : -nrm[i];
    end
    res.hit_x = sm[0][31:0];
    res.hit_y = sm[1][31:0];
    res.hit_z = sm[2][31:0];
    // Tangent axis choice depends on how far w leans toward x.
    wx = w[0] < 0 ? -w[0] : w[0];
    if (wx * 10 > ONE_Q14) ax = '{w[2], 0, -w[0]};
    else                   ax = '{0, -w[2], w[1]};
    unit_vec(ax, u);
    v[0] = (w[1] * u[2] - w[2] * u[1]) >>> 14;
    v[1] = (w[2] * u[0] - w[0] * u[2]) >>> 14;
    v[2] = (w[0] * u[1] - w[1] * u[0]) >>> 14;
    sincos_q14(it.rand_angle, cs, sn);
    r2s = longint'(isqrt_u(rr << 12));
    r1s = longint'(isqrt_u((64'd65536 - rr) << 12));
    for (int i = 0; i < 3; i++) begin
      t     = u[i] * cs * r2s + v[i] * sn * r2s + w[i] * r1s * ONE_Q14;
      sm[i] = t >>> 20;
    end
    unit_vec(sm, bd);
    res.bounce_x = bd[0][15:0];
    res.bounce_y = bd[1][15:0];
    res.bounce_z = bd[2][15:0];
  endtask

  // Send one item, with an optional random gap ahead of it.
  task automatic send_item(input in_t it);
    out_t exp_res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_bounce(it, exp_res);
    bounce_q.push_back(exp_res);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
  endtask

  // Random unit-ish Q2.14 vector.
  task automatic rand_unit(output logic [15:0] x, output logic [15:0] y,
                           output logic [15:0] z);
    longint c[3], o[3];
    for (int i = 0; i < 3; i++) c[i] = longint'($urandom_range(0, 32768)) - 16384;
    unit_vec(c, o);
    x = o[0][15:0];
    y = o[1][15:0];
    z = o[2][15:0];
  endtask

  function automatic in_t noise_item();
    logic [287:0] raw;
    in_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    return it;
  endfunction

  task automatic well_formed(output in_t it);
    it = noise_item();
    rand_unit(it.dir_x, it.dir_y, it.dir_z);
    rand_unit(it.normal_x, it.normal_y, it.normal_z);
    it.distance = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                            : 31'($urandom_range(0, 32'h0040_0000));
    if ($urandom_range(0, 1)) begin
      it.origin_x = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
      it.origin_y = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
      it.origin_z = $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
    end
  endtask

  // Field extremes, saturation, zero normal, flip boundary, axis threshold, angles.
  task automatic test_directed();
    in_t it;
    logic [15:0] angles[8];
    angles = '{16'h0000, 16'h2000, 16'h4000, 16'h6000, 16'h8000, 16'hC000, 16'hE000,
               16'hFFFF};
    it = '0;
    it.dir_z = 16'sd16384;
    it.normal_z = -16'sd16384;
    for (int k = 0; k < 8; k++) begin
      it.rand_angle  = angles[k];
      it.rand_radius = k[0] ? 16'hFFFF : 16'h0000;
      send_item(it);
    end
    it.rand_radius = 16'h8000;
    // Saturation both ways.
    it.origin_x = 32'h7FFF_FFFF; it.origin_y = 32'h8000_0000; it.origin_z = 32'h7FFF_0000;
    it.distance = 31'h7FFF_FFFF;
    it.dir_x = 16'h7FFF; it.dir_y = 16'h8000; it.dir_z = 16'h7FFF;
    send_item(it);
    it.dir_x = 16'h8000; it.dir_y = 16'h7FFF; it.dir_z = 16'h8000;
    it.origin_x = 32'h8000_0000; it.origin_y = 32'h7FFF_FFFF;
    send_item(it);
    // Zero normal, and a normal orthogonal to the ray.
    it = '0;
    it.dir_x = 16'sd16384; it.rand_angle = 16'h1234; it.rand_radius = 16'h4321;
    send_item(it);
    it.normal_y = 16'sd16384;
    send_item(it);
    // Axis threshold: 1638 stays on the x axis, 1639 moves to the y axis.
    it.dir_x = 0; it.dir_z = -16'sd16384;
    it.normal_y = 0; it.normal_z = 16'sd16302;
    it.normal_x = 16'sd1638;  send_item(it);
    it.normal_x = 16'sd1639;  send_item(it);
    it.normal_x = -16'sd1639; send_item(it);
    it.normal_x = -16'sd32768; it.normal_y = -16'sd32768; it.normal_z = -16'sd32768;
    send_item(it);
    it.normal_x = 16'sd32767; it.normal_y = 16'sd32767; it.normal_z = 16'sd32767;
    send_item(it);
    go_idle();
  endtask

  // Mostly well-formed rays with random content, some raw noise.
  task automatic test_random(input int count);
    in_t it;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) it = noise_item();
      else well_formed(it);
      send_item(it);
    end
    go_idle();
  endtask

  // Hold the sender until the pipeline has drained completely.
  task automatic test_drain_pause();
    test_random(40);
    wait (bounce_q.size() == 0);
    repeat (10) @(posedge clk_i);
    test_random(40);
  endtask

  // Back-to-back items with no idling on either side.
  task automatic test_streaming();
    quiet = 1'b1;
    test_random(150);
  endtask

  // Result checker, output stall bursts and watchdog.
  task automatic cmp_field(input string name, input longint e, input longint a);
    if (e != a) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bounce_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data_o);
        end else begin
          e = bounce_q.pop_front();
          cmp_field("hit_x", e.hit_x, out_data_o.hit_x);
          cmp_field("hit_y", e.hit_y, out_data_o.hit_y);
          cmp_field("hit_z", e.hit_z, out_data_o.hit_z);
          cmp_field("bounce_x", e.bounce_x, out_data_o.bounce_x);
          cmp_field("bounce_y", e.bounce_y, out_data_o.bounce_y);
          cmp_field("bounce_z", e.bounce_z, out_data_o.bounce_z);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > STALL_CAP) begin
        $display("end of test: mismatches");
        $finish;
      end
      // Output stall comes in bursts.
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(370);
    test_drain_pause();
    test_streaming();
    wait (bounce_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_errors == 0 && bounce_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/chb_pkg.sv
hw/rtl/chb_isqrt.sv
hw/rtl/chb_norm.sv
hw/rtl/cosine_hemisphere_bounce.sv
tb/cosine_hemisphere_bounce_tb.sv
